### design/scb_pkg.sv
// Shared types, constants and helpers for the segment chainer with bounding box.
package scb_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_W          = 32;
  localparam int TOL_W            = 16;
  localparam int SEG_CNT_W        = 7;
  localparam int CFG_IDX_W        = 3;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 16'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    point_t s;
    point_t e;
  } seg_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } bounds_t;

  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE = 3'd0,
    REG_BOX_MIN_X = 3'd1,
    REG_BOX_MAX_X = 3'd2,
    REG_BOX_MIN_Y = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MIN_Z = 3'd5,
    REG_BOX_MAX_Z = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic flip_last;
    logic flip_seg;
    logic degenerate;
  } orient_t;

  function automatic seg_t swap_ends(seg_t s);
    seg_t r;
    r.s = s.e;
    r.e = s.s;
    return r;
  endfunction

  function automatic bounds_t merge_bounds(bounds_t cb, point_t p, logic use_cb);
    bounds_t r;
    r.min_x = (use_cb && cb.min_x < p.x) ? cb.min_x : p.x;
    r.max_x = (use_cb && cb.max_x > p.x) ? cb.max_x : p.x;
    r.min_y = (use_cb && cb.min_y < p.y) ? cb.min_y : p.y;
    r.max_y = (use_cb && cb.max_y > p.y) ? cb.max_y : p.y;
    r.min_z = (use_cb && cb.min_z < p.z) ? cb.min_z : p.z;
    r.max_z = (use_cb && cb.max_z > p.z) ? cb.max_z : p.z;
    return r;
  endfunction

endpackage

### design/scb_seg_if.sv
// Segment request channel: kind and two endpoints.
interface scb_seg_if;
  import scb_pkg::*;

  logic   valid;
  logic   ready;
  logic   kind;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, kind, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

### design/scb_res_if.sv
// Result channel: acceptance, count, overlap flag and the emitted segment.
interface scb_res_if;
  import scb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic [SEG_CNT_W-1:0] segment_count;
  logic                 overlaps_box;
  logic                 emit_valid;
  coord_t               out_start_x;
  coord_t               out_start_y;
  coord_t               out_start_z;
  coord_t               out_end_x;
  coord_t               out_end_y;
  coord_t               out_end_z;

  modport source (output valid, accepted, segment_count, overlaps_box, emit_valid,
                  out_start_x, out_start_y, out_start_z, out_end_x, out_end_y, out_end_z,
                  input ready);
  modport sink   (input valid, accepted, segment_count, overlaps_box, emit_valid,
                  out_start_x, out_start_y, out_start_z, out_end_x, out_end_y, out_end_z,
                  output ready);
endinterface

### design/scb_cfg_if.sv
// Configuration write channel: register index and write data.
interface scb_cfg_if;
  import scb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/scb_orient.sv
// Endpoint matching: decides flips of the held and new segment, flags degenerate segments.
module scb_orient (
  input  scb_pkg::seg_t               last,
  input  scb_pkg::seg_t               seg,
  input  logic [scb_pkg::TOL_W-1:0]   tolerance,
  input  logic                        chain_en,
  output scb_pkg::orient_t            ctl,
  output scb_pkg::seg_t               last_o,
  output scb_pkg::seg_t               seg_o
);
  import scb_pkg::*;

  function automatic logic near1(coord_t a, coord_t b, logic [TOL_W-1:0] tol);
    logic signed [COORD_W:0] d;
    logic [COORD_W:0]        mag;
    d   = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    mag = d[COORD_W] ? (~d + 1'b1) : d;
    return mag < {{(COORD_W+1-TOL_W){1'b0}}, tol};
  endfunction

  function automatic logic meets(point_t p, point_t q, logic [TOL_W-1:0] tol);
    return near1(p.x, q.x, tol) && near1(p.y, q.y, tol) && near1(p.z, q.z, tol);
  endfunction

  logic m_ee;
  logic m_ss;
  logic m_se;

  always_comb begin
    m_ee = meets(last.e, seg.e, tolerance);
    m_ss = meets(last.s, seg.s, tolerance);
    m_se = meets(last.s, seg.e, tolerance);

    ctl.flip_last  = 1'b0;
    ctl.flip_seg   = 1'b0;
    ctl.degenerate = meets(seg.e, seg.s, tolerance);
    if (chain_en) begin
      priority if (m_ee) begin
        ctl.flip_seg = 1'b1;
      end else if (m_ss) begin
        ctl.flip_last = 1'b1;
      end else if (m_se) begin
        ctl.flip_last = 1'b1;
        ctl.flip_seg  = 1'b1;
      end else begin
        ctl.flip_last = 1'b0;
        ctl.flip_seg  = 1'b0;
      end
    end

    last_o = ctl.flip_last ? swap_ends(last) : last;
    seg_o  = ctl.flip_seg  ? swap_ends(seg)  : seg;
  end
endmodule

### design/scb_bounds.sv
// Overlap test of the face start-point bounds against the query box.
module scb_bounds (
  input  logic             active,
  input  logic             use_cb,
  input  scb_pkg::point_t  p,
  input  scb_pkg::bounds_t cb,
  input  scb_pkg::bounds_t box,
  output logic             hit
);
  import scb_pkg::*;

  bounds_t b;

  always_comb begin
    b   = merge_bounds(cb, p, use_cb);
    hit = active
        && !(b.min_x > box.max_x || b.max_x < box.min_x)
        && !(b.min_y > box.max_y || b.max_y < box.min_y)
        && !(b.min_z > box.max_z || b.max_z < box.min_z);
  end
endmodule

### design/segment_chainer_bbox_core.sv
// Top level of the segment chainer with running start-point bounding box.
// Each request (add segment or finish face) is registered on acceptance and
// resolved against the held segment once the result register advances,
// producing exactly one result; one request per cycle is taken when the
// result channel keeps up. While a result waits, one further request is
// taken and held, then the input stalls until the result is taken. The held
// segment, committed bounds and segment count update in the same cycle as the
// result register, so the combinational chaining step sets the rate.
module segment_chainer_bbox_core #(
  parameter int MAX_SEGMENTS = scb_pkg::MAX_SEGMENTS_DEF
) (
  input logic      clk,
  input logic      rst,
  scb_seg_if.sink  seg_in,
  scb_res_if.source res_out,
  scb_cfg_if.sink  cfg
);
  import scb_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic             s1_valid;
  kind_t            s1_kind;
  seg_t             s1_seg;
  logic             advance;
  logic             fire;

  logic [TOL_W-1:0] tolerance;
  bounds_t          box;

  seg_t             last;
  seg_t             last_next;
  bounds_t          cb;
  bounds_t          cb_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic             chain_en;
  logic             add_ok;
  logic             acc;
  logic             emit_v;
  seg_t             emit_seg;
  orient_t          ctl;
  seg_t             last_o;
  seg_t             seg_o;

  logic             ov_active;
  logic             ov_use_cb;
  point_t           ov_p;
  bounds_t          ov_cb;
  logic             ov_hit;
  logic [CNT_W+SEG_CNT_W-1:0] cnt_ext;

  assign advance      = !res_out.valid || res_out.ready;
  assign fire         = s1_valid && advance;
  assign seg_in.ready = !s1_valid || advance;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (seg_in.ready) begin
      s1_valid <= seg_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_in.valid && seg_in.ready) begin
      s1_kind  <= kind_t'(seg_in.kind);
      s1_seg.s <= '{x: seg_in.start_x, y: seg_in.start_y, z: seg_in.start_z};
      s1_seg.e <= '{x: seg_in.end_x, y: seg_in.end_y, z: seg_in.end_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
      box       <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TOLERANCE: tolerance <= cfg.data[TOL_W-1:0];
        REG_BOX_MIN_X: box.min_x <= cfg.data;
        REG_BOX_MAX_X: box.max_x <= cfg.data;
        REG_BOX_MIN_Y: box.min_y <= cfg.data;
        REG_BOX_MAX_Y: box.max_y <= cfg.data;
        REG_BOX_MIN_Z: box.min_z <= cfg.data;
        REG_BOX_MAX_Z: box.max_z <= cfg.data;
        default: ;
      endcase
    end
  end

  assign chain_en = (count != '0);
  assign add_ok   = (s1_kind == KIND_ADD) && (count < CNT_W'(MAX_SEGMENTS));

  scb_orient u_orient (
    .last      (last),
    .seg       (s1_seg),
    .tolerance (tolerance),
    .chain_en  (chain_en),
    .ctl       (ctl),
    .last_o    (last_o),
    .seg_o     (seg_o)
  );

  assign acc = add_ok && !ctl.degenerate;

  always_comb begin
    last_next  = last;
    cb_next    = cb;
    count_next = count;
    emit_v     = 1'b0;
    emit_seg   = '0;
    if (s1_kind == KIND_FINISH) begin
      emit_v     = chain_en;
      emit_seg   = chain_en ? last : '0;
      last_next  = '0;
      cb_next    = '0;
      count_next = '0;
    end else if (add_ok) begin
      last_next = last_o;
      if (acc) begin
        if (chain_en) begin
          emit_v   = 1'b1;
          emit_seg = last_o;
          cb_next  = merge_bounds(cb, last_o.s, count != CNT_W'(1));
        end
        last_next  = seg_o;
        count_next = count + 1'b1;
      end
    end
  end

  always_comb begin
    if (s1_kind == KIND_FINISH) begin
      ov_active = (count != '0);
      ov_use_cb = (count > CNT_W'(1));
      ov_p      = last.s;
      ov_cb     = cb;
    end else begin
      ov_active = (count_next != '0);
      ov_use_cb = (count_next > CNT_W'(1));
      ov_p      = last_next.s;
      ov_cb     = cb_next;
    end
  end

  scb_bounds u_bounds (
    .active (ov_active),
    .use_cb (ov_use_cb),
    .p      (ov_p),
    .cb     (ov_cb),
    .box    (box),
    .hit    (ov_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= '0;
      cb    <= '0;
      count <= '0;
    end else if (fire) begin
      last  <= last_next;
      cb    <= cb_next;
      count <= count_next;
    end
  end

  assign cnt_ext = {{SEG_CNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_out.valid <= 1'b0;
    end else if (advance) begin
      res_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_out.accepted      <= acc;
      res_out.segment_count <= cnt_ext[SEG_CNT_W-1:0];
      res_out.overlaps_box  <= ov_hit;
      res_out.emit_valid    <= emit_v;
      res_out.out_start_x   <= emit_seg.s.x;
      res_out.out_start_y   <= emit_seg.s.y;
      res_out.out_start_z   <= emit_seg.s.z;
      res_out.out_end_x     <= emit_seg.e.x;
      res_out.out_end_y     <= emit_seg.e.y;
      res_out.out_end_z     <= emit_seg.e.z;
    end
  end
endmodule
